// ===== sv/flae_pkg.sv =====
// package for the frame luma auto exposure unit
// types, constants and helper functions; no dependencies
package flae_pkg;

  localparam int unsigned MaxWidth   = 4096;
  localparam int unsigned MaxHeight  = 4096;
  localparam int unsigned SampleStep = 16;
  localparam int unsigned PosW       = $clog2(MaxWidth) + 1;
  localparam int unsigned SumW       = 24;
  localparam int unsigned CntW       = 17;

  typedef enum logic [2:0] {
    REG_WIDTH     = 3'd0,
    REG_HEIGHT    = 3'd1,
    REG_EXP_MIN   = 3'd2,
    REG_EXP_MAX   = 3'd3,
    REG_GAIN_MAX  = 3'd4,
    REG_EXP_START = 3'd5,
    REG_GAIN_START = 3'd6
  } reg_idx_e;

  typedef enum logic [2:0] {
    ACT_BRIGHT_HOLD = 3'd0,
    ACT_DEADBAND    = 3'd1,
    ACT_WAIT        = 3'd2,
    ACT_EXP_UP      = 3'd3,
    ACT_GAIN_UP     = 3'd4,
    ACT_LIMIT       = 3'd5,
    ACT_GAIN_DOWN   = 3'd6,
    ACT_EXP_DOWN    = 3'd7
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_AVG,
    ST_MUL_PCT,
    ST_DIV_PCT,
    ST_REG,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic           start;
    logic [SumW-1:0] dividend;
    logic [CntW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [SumW-1:0] quotient;
  } div_rsp_t;

  // 5 and 6 bit color widening, v*255/max
  function automatic logic [7:0] widen5(input logic [4:0] v);
    logic [12:0] p;
    p = {5'd0, v, 3'd0} + {5'd0, v, 3'd0} + {5'd0, v, 3'd0} + 13'd0;
    p = 13'({v, 8'd0} - {8'd0, v});
    return 8'(p / 13'd31);
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    logic [13:0] p;
    p = 14'({v, 8'd0} - {8'd0, v});
    return 8'(p / 14'd63);
  endfunction

endpackage

// ===== sv/flae_stream_if.sv =====
// valid/ready channel with a generic payload
// depends on nothing
interface flae_stream_if #(parameter int unsigned W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/flae_divider.sv =====
// restoring divider, one quotient bit per cycle
// depends on flae_pkg
module flae_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  flae_pkg::div_req_t req_i,
  output flae_pkg::div_rsp_t rsp_o
);
  localparam int unsigned NW = flae_pkg::SumW;
  localparam int unsigned DW = flae_pkg::CntW;

  logic [NW-1:0] quo_q, quo_d;
  logic [DW:0]   rem_q, rem_d;
  logic [DW-1:0] den_q, den_d;
  logic [$clog2(NW+1)-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [DW:0] shifted, diff;

  always_comb begin
    shifted = {rem_q[DW-1:0], quo_q[NW-1]};
    diff    = shifted - {1'b0, den_q};
    quo_d = quo_q; rem_d = rem_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    if (req_i.start) begin
      quo_d = req_i.dividend; rem_d = '0; den_d = req_i.divisor;
      cnt_d = ($clog2(NW+1))'(NW); busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[DW]) begin
        rem_d = diff;
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == ($clog2(NW+1))'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;
endmodule

// ===== sv/frame_luma_auto_exposure_unit.sv =====
// top level of the frame luma auto exposure unit
// depends on flae_pkg, flae_stream_if, flae_divider
//
// channel   dir  payload                                         bits
// pix_in    in   {frame_start, pixel}                            17
// res_out   out  {action,error_accum,gain,exposure,bright_pct,avg_luma} 49
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i                 1+3+16
//
// pixels are taken one per cycle while the unit is idle; a pixel that ends a frame
// with samples starts the frame-end sequence: the average divide, the x100, the
// percent divide, the regulator, then the result waits in the output register;
// ready is low through all of that. the shared divider is the only long path.
// reset clears position, statistics and regulator state.
module frame_luma_auto_exposure_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  flae_stream_if.sink          pix_in,
  flae_stream_if.source        res_out,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [15:0]          cfg_data_i
);
  localparam int unsigned PW = flae_pkg::PosW;
  localparam int unsigned CW = flae_pkg::CntW;
  localparam int unsigned SW = flae_pkg::SumW;

  // configuration registers
  logic [12:0] width_q, height_q;
  logic [15:0] exp_min_q, exp_max_q, exp_start_q;
  logic [7:0]  gain_max_q, gain_start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 13'd640; height_q <= 13'd480;
      exp_min_q <= 16'd8; exp_max_q <= 16'd512; gain_max_q <= 8'd0;
      exp_start_q <= 16'd8; gain_start_q <= 8'd0;
    end else if (cfg_we_i) begin
      case (flae_pkg::reg_idx_e'(cfg_idx_i))
        flae_pkg::REG_WIDTH:      width_q <= cfg_data_i[12:0];
        flae_pkg::REG_HEIGHT:     height_q <= cfg_data_i[12:0];
        flae_pkg::REG_EXP_MIN:    exp_min_q <= cfg_data_i;
        flae_pkg::REG_EXP_MAX:    exp_max_q <= cfg_data_i;
        flae_pkg::REG_GAIN_MAX:   gain_max_q <= cfg_data_i[7:0];
        flae_pkg::REG_EXP_START:  exp_start_q <= cfg_data_i;
        flae_pkg::REG_GAIN_START: gain_start_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // effective frame size and sampled spans
  logic [PW-1:0] w_eff, h_eff, xs, xe, ys, ye;
  logic [PW+7:0] wm_p, hm_p;
  logic [PW-1:0] wm, hm;

  always_comb begin
    w_eff = (width_q == '0) ? PW'(1) :
            (width_q > 13'(flae_pkg::MaxWidth)) ? PW'(flae_pkg::MaxWidth) : PW'(width_q);
    h_eff = (height_q == '0) ? PW'(1) :
            (height_q > 13'(flae_pkg::MaxHeight)) ? PW'(flae_pkg::MaxHeight) : PW'(height_q);
    wm_p = (PW+8)'(w_eff) * (PW+8)'(18);
    hm_p = (PW+8)'(h_eff) * (PW+8)'(16);
    wm = PW'(wm_p / (PW+8)'(100));
    hm = PW'(hm_p / (PW+8)'(100));
    // margin never exceeds size, so the far end is size - margin
    xs = (wm > w_eff - 1'b1) ? w_eff - 1'b1 : wm;
    ys = (hm > h_eff - 1'b1) ? h_eff - 1'b1 : hm;
    xe = w_eff - wm; if (xe < xs + 1'b1) xe = xs + 1'b1;
    ye = h_eff - hm; if (ye < ys + 1'b1) ye = ys + 1'b1;
  end

  // state
  flae_pkg::state_e st_q, st_d;
  logic [PW-1:0] col_q, row_q;
  logic [SW-1:0] sum_q;
  logic [CW-1:0] samp_q, brt_q;
  logic [15:0]   exp_q;
  logic [7:0]    gain_q;
  logic signed [6:0] integ_q;
  logic [1:0]    psign_q;
  logic [3:0]    frames_q;
  logic          started_q;
  logic [7:0]    avg_q;
  logic [6:0]    pct_q;
  logic [SW-1:0] pnum_q;
  logic [2:0]    act_q;

  logic pix_acc;
  assign pix_acc = pix_in.valid && pix_in.ready;
  assign pix_in.ready = (st_q == flae_pkg::ST_IDLE);
  assign res_out.valid = (st_q == flae_pkg::ST_OUT);
  assign res_out.data = {act_q, integ_q, gain_q, exp_q, pct_q, avg_q};

  // luma of the incoming pixel
  logic [15:0] pix;
  logic [7:0]  r8, g8, b8, luma;
  logic [17:0] lsum;
  logic [PW-1:0] c0, r0, cdx, rdx;
  logic sampled;

  always_comb begin
    pix = pix_in.data[15:0];
    r8 = flae_pkg::widen5(pix[15:11]);
    g8 = flae_pkg::widen6(pix[10:5]);
    b8 = flae_pkg::widen5(pix[4:0]);
    lsum = 18'(r8) * 18'd77 + 18'(g8) * 18'd150 + 18'(b8) * 18'd29;
    luma = lsum[15:8];
    c0 = pix_in.data[16] ? '0 : col_q;
    r0 = pix_in.data[16] ? '0 : row_q;
    cdx = c0 - xs;
    rdx = r0 - ys;
    sampled = (c0 >= xs) && (c0 < xe) && (cdx % PW'(flae_pkg::SampleStep) == '0) &&
              (r0 >= ys) && (r0 < ye) && (rdx % PW'(flae_pkg::SampleStep) == '0);
  end

  // shared divider
  flae_pkg::div_req_t dreq;
  flae_pkg::div_rsp_t drsp;
  flae_divider u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  // next position and frame end
  logic [SW-1:0] sum_n;
  logic [CW-1:0] samp_n, brt_n;
  logic [PW-1:0] col_n, row_n;
  logic frame_end;

  always_comb begin
    sum_n  = pix_in.data[16] ? '0 : sum_q;
    samp_n = pix_in.data[16] ? '0 : samp_q;
    brt_n  = pix_in.data[16] ? '0 : brt_q;
    if (sampled) begin
      sum_n = sum_n + SW'(luma);
      samp_n = samp_n + 1'b1;
      if (luma >= 8'd210) brt_n = brt_n + 1'b1;
    end
    col_n = c0 + 1'b1;
    row_n = r0;
    frame_end = 1'b0;
    if (col_n >= w_eff) begin
      col_n = '0;
      row_n = r0 + 1'b1;
      if (row_n >= h_eff) begin
        row_n = '0;
        frame_end = 1'b1;
      end
    end
  end

  // regulator, combinational from registered avg/pct
  logic [15:0] r_exp;
  logic [7:0]  r_gain;
  logic signed [6:0] r_int;
  logic [1:0]  r_psign;
  logic [2:0]  r_act;

  always_comb begin
    logic bright, fast, pos;
    logic signed [9:0] err, aerr, db, delta, sint, acc;
    logic [4:0] step;
    logic signed [6:0] half;
    logic [16:0] e_up, e_dn;
    bright = pct_q >= 7'd45;
    db = bright ? 10'sd10 : 10'sd8;
    err = 10'sd148 - $signed({2'b0, avg_q});
    aerr = err < 0 ? -err : err;
    half = integ_q < 0 ? -((-integ_q) >>> 1) : (integ_q >>> 1);
    r_exp = exp_q; r_gain = gain_q; r_int = integ_q; r_psign = psign_q;
    r_act = flae_pkg::ACT_LIMIT;
    pos = err > db;
    fast = (frames_q <= 4'd8) || (aerr >= 10'sd28);
    delta = aerr > 10'sd16 ? 10'sd16 : aerr;
    sint = 10'(integ_q);
    step = aerr >= 10'sd56 ? 5'd24 : aerr >= 10'sd40 ? 5'd18 :
           aerr >= 10'sd24 ? 5'd12 : (fast ? 5'd12 : 5'd8);
    if (bright && !pos && step > 5'd12) step = 5'd12;
    acc = '0;
    e_up = '0; e_dn = '0;
    if (bright && avg_q >= 8'd146 && avg_q <= 8'd170) begin
      r_int = half; r_psign = 2'b00; r_act = flae_pkg::ACT_BRIGHT_HOLD;
    end else if (!pos && !(err < -db)) begin
      r_int = half; r_psign = 2'b00; r_act = flae_pkg::ACT_DEADBAND;
    end else begin
      // sign code: 01 positive, 11 negative
      if (fast) acc = pos ? 10'sd10 : -10'sd10;
      else if (psign_q != (pos ? 2'b01 : 2'b11)) acc = pos ? delta : -delta;
      else begin
        acc = pos ? sint + delta : sint - delta;
        if (acc < -10'sd48) acc = -10'sd48;
        if (acc > 10'sd48) acc = 10'sd48;
      end
      r_int = 7'(acc);
      r_psign = pos ? 2'b01 : 2'b11;
      if (!fast && acc > -10'sd10 && acc < 10'sd10) r_act = flae_pkg::ACT_WAIT;
      else if (pos) begin
        if (17'(exp_q) + 17'd6 < 17'(exp_max_q)) begin
          e_up = 17'(exp_q) + 17'(step);
          r_exp = (e_up < 17'(exp_min_q)) ? exp_min_q :
                  (e_up > 17'(exp_max_q)) ? exp_max_q : e_up[15:0];
          r_int = '0; r_act = flae_pkg::ACT_EXP_UP;
        end else if (gain_q < gain_max_q) begin
          r_gain = gain_q + 1'b1; r_int = '0; r_act = flae_pkg::ACT_GAIN_UP;
        end
      end else begin
        if (gain_q != '0) begin
          r_gain = gain_q - 1'b1; r_int = '0; r_act = flae_pkg::ACT_GAIN_DOWN;
        end else if (exp_q > exp_min_q) begin
          e_dn = (exp_q > 16'(step)) ? 17'(exp_q - 16'(step)) : 17'(exp_min_q);
          r_exp = (e_dn < 17'(exp_min_q)) ? exp_min_q :
                  (e_dn > 17'(exp_max_q)) ? exp_max_q : e_dn[15:0];
          r_int = '0; r_act = flae_pkg::ACT_EXP_DOWN;
        end
      end
    end
  end

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      flae_pkg::ST_IDLE:
        if (pix_acc && frame_end && samp_n != '0) st_d = flae_pkg::ST_DIV_AVG;
      flae_pkg::ST_DIV_AVG: if (drsp.done) st_d = flae_pkg::ST_MUL_PCT;
      flae_pkg::ST_MUL_PCT: st_d = flae_pkg::ST_DIV_PCT;
      flae_pkg::ST_DIV_PCT: if (drsp.done) st_d = flae_pkg::ST_REG;
      flae_pkg::ST_REG: st_d = flae_pkg::ST_OUT;
      flae_pkg::ST_OUT: if (res_out.ready) st_d = flae_pkg::ST_IDLE;
      default: st_d = flae_pkg::ST_IDLE;
    endcase
  end

  // divider requests
  always_comb begin
    dreq.start = 1'b0;
    dreq.dividend = sum_n;
    dreq.divisor = samp_n;
    case (st_q)
      flae_pkg::ST_IDLE:
        dreq.start = pix_acc && frame_end && samp_n != '0;
      flae_pkg::ST_MUL_PCT: begin
        dreq.start = 1'b1;
        dreq.dividend = pnum_q;
        dreq.divisor = samp_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= flae_pkg::ST_IDLE;
      col_q <= '0; row_q <= '0; sum_q <= '0; samp_q <= '0; brt_q <= '0;
      exp_q <= '0; gain_q <= '0; integ_q <= '0; psign_q <= '0;
      frames_q <= '0; started_q <= 1'b0;
    end else begin
      st_q <= st_d;
      case (st_q)
        flae_pkg::ST_IDLE: if (pix_acc) begin
          col_q <= col_n; row_q <= row_n;
          if (frame_end) begin
            // divisor for the percent divide is kept in samp_q
            sum_q <= '0; samp_q <= samp_n; brt_q <= brt_n;
            if (!started_q) begin
              exp_q <= (exp_start_q < exp_min_q) ? exp_min_q :
                       (exp_start_q > exp_max_q) ? exp_max_q : exp_start_q;
              gain_q <= (gain_start_q > gain_max_q) ? gain_max_q : gain_start_q;
              started_q <= 1'b1;
            end
            if (frames_q < 4'd9) frames_q <= frames_q + 1'b1;
          end else begin
            sum_q <= sum_n; samp_q <= samp_n; brt_q <= brt_n;
          end
        end
        flae_pkg::ST_REG: begin
          exp_q <= r_exp; gain_q <= r_gain; integ_q <= r_int; psign_q <= r_psign;
        end
        flae_pkg::ST_OUT: if (res_out.ready) begin
          samp_q <= '0; brt_q <= '0;
        end
        default: ;
      endcase
    end
  end

  // a frame end without samples leaves stale counts; clear them
  // (handled: samp_n zero means samp_q is zero already after the write)

  always_ff @(posedge clk_i) begin
    if (st_q == flae_pkg::ST_DIV_AVG && drsp.done) begin
      avg_q  <= drsp.quotient[7:0];
      pnum_q <= SW'(brt_q) * SW'(100);
    end
    if (st_q == flae_pkg::ST_DIV_PCT && drsp.done) pct_q <= drsp.quotient[6:0];
    if (st_q == flae_pkg::ST_REG) act_q <= r_act;
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != flae_pkg::ST_IDLE) |-> !pix_in.ready) else $error("ready while busy");
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_out.valid && !res_out.ready) |=> $stable(res_out.data)) else $error("result moved");
  a_integ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (integ_q >= -7'sd48 && integ_q <= 7'sd48)) else $error("integrator range");
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_out.valid |-> (pct_q <= 7'd100)) else $error("percent range");
`endif
endmodule

// ===== dv/testbench.sv =====
// self-checking testbench for the frame luma auto exposure unit
// depends on flae_pkg, flae_stream_if and the unit's rtl
module testbench;
  import flae_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // one frame report as it leaves the unit
  typedef struct packed {
    action_e     action;
    logic [6:0]  error_accum;
    logic [7:0]  gain;
    logic [15:0] exposure;
    logic [6:0]  bright_pct;
    logic [7:0]  avg_luma;
  } report_t;

  localparam logic [2:0] RegUnused = 3'd7;
  localparam int unsigned WatchLimit = 5000;
  localparam int unsigned SettleCycles = 80;

  localparam logic [15:0] PixWhite = 16'hFFFF;
  localparam logic [15:0] PixBlack = 16'h0000;
  localparam logic [15:0] PixGray  = 16'h94B2;
  localparam logic [15:0] PixDark  = 16'h3186;

  logic clk_i;
  logic rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  flae_stream_if #(.W(17)) pix_ch ();
  flae_stream_if #(.W($bits(report_t))) res_ch ();

  frame_luma_auto_exposure_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_in     (pix_ch.sink),
    .res_out    (res_ch.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // 2 ns clock
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow of the register file
  int unsigned sh_width, sh_height, sh_exp_min, sh_exp_max;
  int unsigned sh_gain_max, sh_exp_start, sh_gain_start;

  // shadow of the unit's running state
  int unsigned col_at, row_at;
  longint unsigned luma_acc;
  int unsigned samples_seen, bright_seen;
  int unsigned exp_now, gain_now, frame_ends;
  int          integ, last_sign;
  bit          loaded;

  report_t frame_reports_due[$];

  int unsigned mismatches, reports_checked, pixels_sent, cfg_writes;
  int unsigned idle_cycles;
  int unsigned stall_requests, stalls_served;
  bit          quiet;   // no gaps on either side while set
  bit [7:0]    actions_seen;

  function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int halve(int v);
    return v < 0 ? -((-v) / 2) : v / 2;
  endfunction

  function automatic int iabs(int v);
    return v < 0 ? -v : v;
  endfunction

  // sampled window along one axis, end exclusive
  function automatic void window(input int unsigned size, input int unsigned pct,
                                 output int unsigned lo, output int unsigned hi);
    int unsigned m, e;
    m = (size * pct) / 100;
    lo = (m > size - 1) ? size - 1 : m;
    e = size - m;
    if (m > size) e = 0;
    hi = clampu(e, lo + 1, size);
  endfunction

  // exposure / gain regulator, returns the action taken
  function automatic action_e regulate(int unsigned avg, int unsigned pct);
    bit bright;
    int dband, err, sgn, delta;
    bit fast;
    int unsigned stp, nxt;
    int a;
    bright = pct >= 45;
    dband = bright ? 10 : 8;
    err = 148 - int'(avg);
    if (bright && avg >= 146 && avg <= 170) begin
      integ = halve(integ);
      last_sign = 0;
      return ACT_BRIGHT_HOLD;
    end
    if (err > dband) sgn = 1;
    else if (err < -dband) sgn = -1;
    else begin
      integ = halve(integ);
      last_sign = 0;
      return ACT_DEADBAND;
    end
    fast = frame_ends <= 8 || iabs(err) >= 28;
    delta = iabs(err);
    if (delta > 16) delta = 16;
    if (fast) integ = sgn * 10;
    else if (last_sign != sgn) integ = sgn * delta;
    else begin
      integ += sgn * delta;
      if (integ < -48) integ = -48;
      if (integ > 48) integ = 48;
    end
    last_sign = sgn;
    if (!fast && iabs(integ) < 10) return ACT_WAIT;
    a = iabs(err);
    if (a >= 56) stp = 24;
    else if (a >= 40) stp = 18;
    else if (a >= 24) stp = 12;
    else stp = fast ? 12 : 8;
    if (bright && sgn < 0 && stp > 12) stp = 12;
    if (sgn > 0) begin
      if (exp_now + 6 < sh_exp_max) begin
        exp_now = clampu(exp_now + stp, sh_exp_min, sh_exp_max);
        integ = 0;
        return ACT_EXP_UP;
      end
      if (gain_now < sh_gain_max) begin
        gain_now++;
        integ = 0;
        return ACT_GAIN_UP;
      end
      return ACT_LIMIT;
    end
    if (gain_now > 0) begin
      gain_now--;
      integ = 0;
      return ACT_GAIN_DOWN;
    end
    if (exp_now > sh_exp_min) begin
      nxt = exp_now > stp ? exp_now - stp : sh_exp_min;
      exp_now = clampu(nxt, sh_exp_min, sh_exp_max);
      integ = 0;
      return ACT_EXP_DOWN;
    end
    return ACT_LIMIT;
  endfunction

  // advance the shadow by one accepted pixel, queue a report at frame end
  function automatic void account_pixel(logic [15:0] pix, logic fs);
    int unsigned w, h, xs, xe, ys, ye, r, g, b, y, avg, pct;
    report_t rep;
    action_e act;
    w = clampu(sh_width, 1, MaxWidth);
    h = clampu(sh_height, 1, MaxHeight);
    if (fs) begin
      col_at = 0;
      row_at = 0;
      luma_acc = 0;
      samples_seen = 0;
      bright_seen = 0;
    end
    window(w, 18, xs, xe);
    window(h, 16, ys, ye);
    if (col_at >= xs && col_at < xe && (col_at - xs) % SampleStep == 0 &&
        row_at >= ys && row_at < ye && (row_at - ys) % SampleStep == 0) begin
      r = (int'(pix[15:11]) * 255) / 31;
      g = (int'(pix[10:5]) * 255) / 63;
      b = (int'(pix[4:0]) * 255) / 31;
      y = (77 * r + 150 * g + 29 * b) >> 8;
      luma_acc += y;
      if (y >= 210) bright_seen++;
      samples_seen++;
    end
    col_at++;
    if (col_at < w) return;
    col_at = 0;
    row_at++;
    if (row_at < h) return;
    row_at = 0;
    if (!loaded) begin
      exp_now = clampu(sh_exp_start, sh_exp_min, sh_exp_max);
      gain_now = sh_gain_start > sh_gain_max ? sh_gain_max : sh_gain_start;
      loaded = 1'b1;
    end
    if (frame_ends < 9) frame_ends++;
    if (samples_seen == 0) begin
      luma_acc = 0;
      bright_seen = 0;
      return;
    end
    avg = int'(luma_acc / samples_seen);
    pct = (bright_seen * 100) / samples_seen;
    luma_acc = 0;
    samples_seen = 0;
    bright_seen = 0;
    act = regulate(avg, pct);
    rep.avg_luma = avg[7:0];
    rep.bright_pct = pct[6:0];
    rep.exposure = exp_now[15:0];
    rep.gain = gain_now[7:0];
    rep.error_accum = integ[6:0];
    rep.action = act;
    frame_reports_due.push_back(rep);
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // offer one pixel beat and wait for it to be taken; valid stays high after
  task automatic send_pixel(logic [15:0] pix, logic fs);
    int unsigned gap;
    gap = gap_len();
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.data <= {fs, pix};
    do @(posedge clk_i); while (!pix_ch.ready);
    account_pixel(pix, fs);
    pixels_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    pix_ch.valid <= 1'b0;
    wait (frame_reports_due.size() == 0);
    // frame end without samples leaves nothing to wait for, so settle
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // register write; caller makes sure the unit is idle
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_writes++;
    case (idx)
      REG_WIDTH:      sh_width = val & 16'h1FFF;
      REG_HEIGHT:     sh_height = val & 16'h1FFF;
      REG_EXP_MIN:    sh_exp_min = val;
      REG_EXP_MAX:    sh_exp_max = val;
      REG_GAIN_MAX:   sh_gain_max = val & 16'h00FF;
      REG_EXP_START:  sh_exp_start = val;
      REG_GAIN_START: sh_gain_start = val & 16'h00FF;
      default: ;
    endcase
  endtask

  task automatic set_size(int unsigned w, int unsigned h);
    write_reg(REG_WIDTH, w[15:0]);
    write_reg(REG_HEIGHT, h[15:0]);
  endtask

  function automatic logic [15:0] pick_pixel();
    case ($urandom_range(0, 5))
      0: return PixWhite;
      1: return PixBlack;
      2: return PixGray;
      3: return PixDark;
      default: return 16'($urandom());
    endcase
  endfunction

  // one whole frame, frame start flag on the first pixel when flag is set
  task automatic send_frame(bit flag);
    int unsigned n;
    n = clampu(sh_width, 1, MaxWidth) * clampu(sh_height, 1, MaxHeight);
    for (int unsigned i = 0; i < n; i++)
      send_pixel(pick_pixel(), flag && i == 0);
  endtask

  // receiver side: random ready, long hold-off on request
  int unsigned sink_hold;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      sink_hold <= 0;
    end else if (stall_requests != stalls_served) begin
      stalls_served <= stall_requests;
      sink_hold <= 400;
      res_ch.ready <= 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      res_ch.ready <= 1'b0;
    end else if (quiet || $urandom_range(0, 99) < 70) begin
      res_ch.ready <= 1'b1;
    end else begin
      res_ch.ready <= 1'b0;
      sink_hold <= gap_len();
    end
  end

  // report checker: each report beat against the oldest expectation
  always @(posedge clk_i) begin
    report_t got, want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got = report_t'(res_ch.data);
      if (frame_reports_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected report beat %h", got);
      end else begin
        want = frame_reports_due.pop_front();
        reports_checked++;
        actions_seen[want.action] = 1'b1;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("report mismatch: avg %0d/%0d pct %0d/%0d exp %0d/%0d gain %0d/%0d int %0d/%0d act %0d/%0d (exp/got)",
                     want.avg_luma, got.avg_luma, want.bright_pct, got.bright_pct,
                     want.exposure, got.exposure, want.gain, got.gain,
                     $signed(want.error_accum), $signed(got.error_accum),
                     want.action, got.action);
        end
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk_i) begin
    if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchLimit) begin
      $display("watchdog: no beat for %0d cycles", idle_cycles);
      $display("** frame_luma_auto_exposure_unit: FAILED **");
      $finish;
    end
  end

  // first frame end loads clamped start values; colors at their extremes
  task automatic test_directed();
    logic [15:0] px[13];
    px = '{PixWhite, PixBlack, 16'hF800, 16'h07E0, 16'h001F, PixGray, PixGray,
           PixDark, PixWhite, PixWhite, PixBlack, 16'h8410, 16'h7BEF};
    write_reg(REG_EXP_MIN, 16'd100);
    write_reg(REG_EXP_MAX, 16'd200);
    write_reg(REG_EXP_START, 16'hFFFF);
    write_reg(REG_GAIN_MAX, 16'd3);
    write_reg(REG_GAIN_START, 16'hFFFF);
    write_reg(RegUnused, 16'hFFFF);
    set_size(1, 1);
    foreach (px[i]) send_pixel(px[i], i[0]);
    drain();
    // start registers no longer matter after the first load
    write_reg(REG_EXP_START, 16'd0);
    write_reg(REG_GAIN_START, 16'd0);
    set_size(0, 0);
    for (int i = 0; i < 6; i++) send_pixel(PixBlack, 1'b0);
    drain();
  endtask

  // the largest line and column, sizes beyond the maximum clamp
  task automatic test_size_limits();
    set_size(16'h1FFF, 1);
    send_frame(1'b1);
    drain();
    set_size(1, 16'hFFFF);
    send_frame(1'b1);
    drain();
  endtask

  // shrink the frame with a partial frame pending: it ends without samples, no report
  task automatic test_resize_mid_frame();
    set_size(32, 32);
    for (int i = 0; i < 100; i++) send_pixel(pick_pixel(), i == 0);
    drain();
    set_size(1, 1);
    send_pixel(PixGray, 1'b0);
    send_pixel(PixWhite, 1'b0);
    drain();
  endtask

  // receiver holds off while pixels keep coming, the unit has to stall its input
  task automatic test_backpressure();
    set_size(1, 1);
    stall_requests++;
    for (int i = 0; i < 12; i++) send_pixel(pick_pixel(), 1'b0);
    drain();
  endtask

  // random settings, mostly well-formed frames, some restarts mid-frame
  task automatic test_random();
    int unsigned sel, frames;
    while (pixels_sent < 1350 + 8400) begin
      quiet = $urandom_range(0, 3) == 0;
      case ($urandom_range(0, 5))
        0: write_reg(REG_EXP_MIN, 16'd0);
        1: write_reg(REG_EXP_MIN, 16'($urandom_range(0, 600)));
        2: write_reg(REG_EXP_MAX, 16'hFFFF);
        3: write_reg(REG_EXP_MAX, 16'($urandom_range(0, 700)));
        4: write_reg(REG_GAIN_MAX, 16'($urandom_range(0, 1) ? 255 : $urandom_range(0, 4)));
        default: write_reg(REG_GAIN_MAX, 16'd0);
      endcase
      sel = $urandom_range(0, 9);
      if (sel < 5) set_size($urandom_range(0, 3), $urandom_range(0, 2));
      else if (sel < 9) set_size(40, $urandom_range(1, 3));
      else set_size($urandom_range(16, 48), $urandom_range(16, 20));
      frames = $urandom_range(3, 10);
      for (int unsigned f = 0; f < frames; f++) begin
        if ($urandom_range(0, 9) == 0) begin
          // broken frame: a few pixels, then a restart
          for (int unsigned k = $urandom_range(1, 5); k > 0; k--)
            send_pixel(pick_pixel(), $urandom_range(0, 1));
        end
        send_frame($urandom_range(0, 3) != 0);
      end
      drain();
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_WIDTH;
    cfg_data_i = '0;
    pix_ch.valid = 1'b0;
    pix_ch.data = '0;
    quiet = 1'b0;
    stall_requests = 0;
    mismatches = 0;
    reports_checked = 0;
    pixels_sent = 0;
    cfg_writes = 0;
    idle_cycles = 0;
    actions_seen = '0;
    sh_width = 640; sh_height = 480;
    sh_exp_min = 8; sh_exp_max = 512; sh_gain_max = 0;
    sh_exp_start = 8; sh_gain_start = 0;
    col_at = 0; row_at = 0; luma_acc = 0;
    samples_seen = 0; bright_seen = 0;
    exp_now = 0; gain_now = 0; frame_ends = 0;
    integ = 0; last_sign = 0; loaded = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_size_limits();
    test_resize_mid_frame();
    test_backpressure();
    test_random();
    test_backpressure();
    drain();

    $display("%0d pixels, %0d frame reports checked, %0d register writes", pixels_sent,
             reports_checked, cfg_writes);
    $display("regulator actions seen (bit per action): %b", actions_seen);
    if (mismatches == 0 && frame_reports_due.size() == 0) begin
      $display("** frame_luma_auto_exposure_unit: PASSED **");
    end else begin
      $display("%0d mismatches, %0d reports missing", mismatches, frame_reports_due.size());
      $display("** frame_luma_auto_exposure_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/flae_pkg.sv
sv/flae_stream_if.sv
sv/flae_divider.sv
sv/frame_luma_auto_exposure_unit.sv
dv/testbench.sv
